// ===== src/rcws_pkg.sv =====
// Package for the rich-text control word stripper: payload types, parser mode
// encoding and the character classification and control word helpers.
// No dependencies.
package rcws_pkg;

  localparam int DEPTH_BITS = 16;

  typedef logic [15:0]           unit_t;
  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [2:0]            word_t;

  typedef enum logic [8:0] {
    M_PLAIN  = 9'b000000001,
    M_OBRACE = 9'b000000010,
    M_OBS    = 9'b000000100,
    M_IGNORE = 9'b000001000,
    M_ESC    = 9'b000010000,
    M_HEX1   = 9'b000100000,
    M_HEX2   = 9'b001000000,
    M_CTRL   = 9'b010000000,
    M_NUM    = 9'b100000000
  } mode_t;

  localparam word_t WM_EMPTY = 3'd0;
  localparam word_t WM_PAR   = 3'd1;
  localparam word_t WM_LINE  = 3'd2;
  localparam word_t WM_TAB   = 3'd3;
  localparam word_t WM_NONE  = 3'd7;
  localparam word_t LEN_MAX  = 3'd7;

  localparam unit_t CH_LF     = 16'h000A;
  localparam unit_t CH_CR     = 16'h000D;
  localparam unit_t CH_TAB    = 16'h0009;
  localparam unit_t CH_SPACE  = 16'h0020;
  localparam unit_t CH_QUOTE  = 16'h0027;
  localparam unit_t CH_STAR   = 16'h002A;
  localparam unit_t CH_MINUS  = 16'h002D;
  localparam unit_t CH_BSLASH = 16'h005C;
  localparam unit_t CH_LBRACE = 16'h007B;
  localparam unit_t CH_RBRACE = 16'h007D;
  localparam unit_t CH_P      = 16'h0070;
  localparam unit_t CH_L      = 16'h006C;
  localparam unit_t CH_T      = 16'h0074;

  function automatic logic is_letter(input unit_t c);
    return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
  endfunction

  function automatic logic is_digit(input unit_t c);
    return c >= 16'h0030 && c <= 16'h0039;
  endfunction

  function automatic logic is_hex(input unit_t c);
    return is_digit(c) || (c >= 16'h0041 && c <= 16'h0046) ||
           (c >= 16'h0061 && c <= 16'h0066);
  endfunction

  function automatic logic [3:0] hex_val(input unit_t c);
    logic [3:0] v;
    v = 4'd0;
    if (is_digit(c)) begin
      v = c[3:0];
    end else if (is_hex(c)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic word_t word_size(input word_t m);
    word_t s;
    case (m)
      WM_PAR:  s = 3'd3;
      WM_LINE: s = 3'd4;
      WM_TAB:  s = 3'd3;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic unit_t word_unit(input word_t m);
    return (m == WM_TAB) ? CH_TAB : CH_LF;
  endfunction

  function automatic unit_t word_char(input word_t m, input word_t len);
    unit_t ch;
    ch = 16'h0000;
    case (m)
      WM_PAR: begin
        case (len)
          3'd0:    ch = 16'h0070;
          3'd1:    ch = 16'h0061;
          3'd2:    ch = 16'h0072;
          default: ch = 16'h0000;
        endcase
      end
      WM_LINE: begin
        case (len)
          3'd0:    ch = 16'h006C;
          3'd1:    ch = 16'h0069;
          3'd2:    ch = 16'h006E;
          3'd3:    ch = 16'h0065;
          default: ch = 16'h0000;
        endcase
      end
      WM_TAB: begin
        case (len)
          3'd0:    ch = 16'h0074;
          3'd1:    ch = 16'h0061;
          3'd2:    ch = 16'h0062;
          default: ch = 16'h0000;
        endcase
      end
      default: ch = 16'h0000;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/rcws_channels.sv =====
// Valid/ready channel interfaces for the rich-text input stream and the
// plain-text output stream. Depends on rcws_pkg.
interface rcws_in_if;
  import rcws_pkg::*;

  logic  valid;
  logic  ready;
  unit_t text_unit;
  logic  end_of_text;

  modport source (output valid, output text_unit, output end_of_text, input ready);
  modport sink   (input valid, input text_unit, input end_of_text, output ready);
endinterface

interface rcws_out_if;
  import rcws_pkg::*;

  logic  valid;
  logic  ready;
  unit_t out_unit;
  logic  last_of_run;

  modport source (output valid, output out_unit, output last_of_run, input ready);
  modport sink   (input valid, input out_unit, input last_of_run, output ready);
endinterface

// ===== src/rtf_control_word_stripper_unit.sv =====
// Top level of the rich-text control word stripper: input register, parser
// state update and a two-entry result register. Depends on rcws_pkg and the
// channel interfaces in rcws_channels.sv.
//
//   channel | direction | payload                    | requests per item
//   rx      | in        | text_unit, end_of_text     | 1
//   tx      | out       | out_unit, last_of_run      | 0, 1 or 2
//
// An accepted unit is parsed while it waits in the input register, once the result
// register has room, and its results are then shown from the result register.
// A unit with at most one result is taken every cycle while tx is ready; one with
// two results holds the parser while the result register drains.
// Reset is synchronous and returns the parser to plain text with depth zero.
// A stall on tx fills the result register and then the input register.
module rtf_control_word_stripper_unit (
  input  logic             clk,
  input  logic             rst,
  rcws_in_if.sink          rx,
  rcws_out_if.source       tx
);
  import rcws_pkg::*;

  logic   in_valid;
  unit_t  in_unit;
  logic   in_eot;

  mode_t  mode;
  word_t  word_match;
  word_t  word_len;
  logic [3:0] hex_high;
  logic   hex_ok;
  depth_t group_depth;

  mode_t  mode_next;
  word_t  word_match_next;
  word_t  word_len_next;
  logic [3:0] hex_high_next;
  logic   hex_ok_next;
  depth_t group_depth_next;

  logic [1:0] out_cnt;
  unit_t  slot0_unit;
  logic   slot0_last;
  unit_t  slot1_unit;

  logic   out_pop;
  logic   proc_fire;

  mode_t  p_mode;
  logic   p_emit;
  mode_t  te_mode;
  logic   te_emit;
  word_t  al0_match;
  word_t  al_match;
  word_t  al_len;
  logic   word_hit;
  logic   emit_w1;
  logic   emit_u;
  logic   emit_w2;
  unit_t  u_val;
  unit_t  w2_val;
  logic [1:0] res_cnt;
  unit_t  res0;
  unit_t  res1;

  assign out_pop   = tx.valid && tx.ready;
  assign proc_fire = in_valid && (out_cnt == 2'd0 || (out_cnt == 2'd1 && out_pop));
  assign rx.ready  = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_unit <= rx.text_unit;
      in_eot  <= rx.end_of_text;
    end
  end

  always_comb begin
    // Plain text handling of the current unit.
    p_mode = M_PLAIN;
    p_emit = 1'b0;
    if (in_unit == CH_LBRACE) begin
      p_mode = M_OBRACE;
    end else if (in_unit == CH_BSLASH) begin
      p_mode = M_ESC;
    end else if (in_unit != CH_RBRACE && in_unit != CH_LF && in_unit != CH_CR) begin
      p_emit = 1'b1;
    end

    // Handling of the unit that ends a control word.
    te_mode = p_mode;
    te_emit = p_emit;
    if (in_unit == CH_SPACE) begin
      te_mode = M_PLAIN;
      te_emit = 1'b0;
    end else if (is_digit(in_unit) || in_unit == CH_MINUS) begin
      te_mode = M_NUM;
      te_emit = 1'b0;
    end

    // Control word letter matching.
    if (in_unit == CH_P) begin
      al0_match = WM_PAR;
    end else if (in_unit == CH_L) begin
      al0_match = WM_LINE;
    end else if (in_unit == CH_T) begin
      al0_match = WM_TAB;
    end else begin
      al0_match = WM_NONE;
    end
    if (word_match == WM_EMPTY) begin
      al_match = al0_match;
    end else if (word_match == WM_PAR || word_match == WM_LINE || word_match == WM_TAB) begin
      al_match = (word_len < word_size(word_match) &&
                  word_char(word_match, word_len) == in_unit) ? word_match : WM_NONE;
    end else begin
      al_match = word_match;
    end
    al_len   = (word_len < LEN_MAX) ? word_len + 3'd1 : LEN_MAX;
    word_hit = (word_match == WM_PAR || word_match == WM_LINE || word_match == WM_TAB) &&
               word_len == word_size(word_match);
  end

  always_comb begin
    mode_next        = mode;
    word_match_next  = word_match;
    word_len_next    = word_len;
    hex_high_next    = hex_high;
    hex_ok_next      = hex_ok;
    group_depth_next = group_depth;
    emit_w1          = 1'b0;
    emit_u           = 1'b0;
    u_val            = in_unit;

    case (mode)
      M_PLAIN: begin
        mode_next = p_mode;
        emit_u    = p_emit;
      end
      M_OBRACE: begin
        if (in_unit == CH_BSLASH) begin
          mode_next = M_OBS;
        end else begin
          mode_next = p_mode;
          emit_u    = p_emit;
        end
      end
      M_OBS, M_ESC: begin
        if (mode == M_OBS && in_unit == CH_STAR) begin
          mode_next        = M_IGNORE;
          group_depth_next = depth_t'(1);
        end else if (in_unit == CH_BSLASH || in_unit == CH_LBRACE ||
                     in_unit == CH_RBRACE) begin
          mode_next = M_PLAIN;
          emit_u    = 1'b1;
        end else if (in_unit == CH_QUOTE) begin
          mode_next = M_HEX1;
        end else if (is_letter(in_unit)) begin
          mode_next       = M_CTRL;
          word_match_next = al0_match;
          word_len_next   = 3'd1;
        end else begin
          mode_next = te_mode;
          emit_u    = te_emit;
        end
      end
      M_IGNORE: begin
        if (in_unit == CH_LBRACE) begin
          if (group_depth != '1) begin
            group_depth_next = group_depth + depth_t'(1);
          end
        end else if (in_unit == CH_RBRACE) begin
          if (group_depth != '0) begin
            group_depth_next = group_depth - depth_t'(1);
          end
          if (group_depth <= depth_t'(1)) begin
            mode_next = M_PLAIN;
          end
        end
      end
      M_CTRL: begin
        if (is_letter(in_unit)) begin
          word_match_next = al_match;
          word_len_next   = al_len;
        end else begin
          emit_w1         = word_hit;
          word_match_next = WM_EMPTY;
          word_len_next   = 3'd0;
          mode_next       = te_mode;
          emit_u          = te_emit;
        end
      end
      M_NUM: begin
        if (!(is_digit(in_unit) || in_unit == CH_MINUS)) begin
          if (in_unit == CH_SPACE) begin
            mode_next = M_PLAIN;
          end else begin
            mode_next = p_mode;
            emit_u    = p_emit;
          end
        end
      end
      M_HEX1: begin
        hex_ok_next   = is_hex(in_unit);
        hex_high_next = hex_val(in_unit);
        mode_next     = M_HEX2;
      end
      M_HEX2: begin
        emit_u        = hex_ok && is_hex(in_unit);
        u_val         = {8'h00, hex_high, hex_val(in_unit)};
        hex_ok_next   = 1'b0;
        hex_high_next = 4'd0;
        mode_next     = M_PLAIN;
      end
      default: begin
        mode_next = p_mode;
        emit_u    = p_emit;
      end
    endcase

    // End of text flushes a finished control word and returns to reset state.
    emit_w2 = 1'b0;
    w2_val  = word_unit(word_match_next);
    if (in_eot) begin
      emit_w2 = mode_next == M_CTRL &&
                (word_match_next == WM_PAR || word_match_next == WM_LINE ||
                 word_match_next == WM_TAB) &&
                word_len_next == word_size(word_match_next);
      mode_next        = M_PLAIN;
      word_match_next  = WM_EMPTY;
      word_len_next    = 3'd0;
      hex_high_next    = 4'd0;
      hex_ok_next      = 1'b0;
      group_depth_next = '0;
    end

    res_cnt = 2'(emit_w1) + 2'(emit_u) + 2'(emit_w2);
    if (emit_w1) begin
      res0 = word_unit(word_match);
    end else if (emit_u) begin
      res0 = u_val;
    end else begin
      res0 = w2_val;
    end
    res1 = (emit_w1 && emit_u) ? u_val : w2_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_PLAIN;
      word_match  <= WM_EMPTY;
      word_len    <= 3'd0;
      hex_high    <= 4'd0;
      hex_ok      <= 1'b0;
      group_depth <= '0;
    end else if (proc_fire) begin
      mode        <= mode_next;
      word_match  <= word_match_next;
      word_len    <= word_len_next;
      hex_high    <= hex_high_next;
      hex_ok      <= hex_ok_next;
      group_depth <= group_depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (proc_fire) begin
      out_cnt <= res_cnt;
    end else if (out_pop) begin
      out_cnt <= out_cnt - 2'd1;
    end
    if (proc_fire) begin
      slot0_unit <= res0;
      slot0_last <= res_cnt == 2'd1;
      slot1_unit <= res1;
    end else if (out_pop) begin
      slot0_unit <= slot1_unit;
      slot0_last <= 1'b1;
    end
  end

  assign tx.valid       = out_cnt != 2'd0;
  assign tx.out_unit    = slot0_unit;
  assign tx.last_of_run = slot0_last;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_cnt != 2'd3)
    else $error("result count out of range");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !proc_fire |=> in_valid && $stable(in_unit) && $stable(in_eot))
    else $error("held input item lost or changed");

  a_ignore_depth: assert property (@(posedge clk) disable iff (rst)
    mode == M_IGNORE |-> group_depth != '0)
    else $error("dropped group with zero depth");

  a_eot_reset: assert property (@(posedge clk) disable iff (rst)
    proc_fire && in_eot |=> mode == M_PLAIN && group_depth == '0 && !hex_ok)
    else $error("parser state not reset after end of text");

endmodule
